/* src/assert_macros.svh */
// Assertion macros for the game port paddle and switch RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define GPPS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Condition must never be seen at a clock edge outside reset.
`define GPPS_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`else

`define GPPS_ASSERT(name, clk, rst, prop)
`define GPPS_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

/* src/gpps_pkg.sv */
// Types, codes and helpers for the game port paddle and switch block.
`default_nettype none

package gpps_pkg;

   localparam int MAX_CHANNELS         = 4;
   localparam int NUM_CHANNELS_DEFAULT = 4;
   localparam int CHAN_W               = 2;
   localparam int LIMIT_W              = 12;

   localparam logic [LIMIT_W-1:0] MID_LIMIT = 12'd1410;

   // request action codes
   localparam logic [2:0] ACT_READ       = 3'd0;
   localparam logic [2:0] ACT_WRITE      = 3'd1;
   localparam logic [2:0] ACT_SET_PADDLE = 3'd2;
   localparam logic [2:0] ACT_SET_BUTTON = 3'd3;
   localparam logic [2:0] ACT_POWER_OFF  = 3'd4;

   typedef struct packed {
      logic [2:0]        action;
      logic [5:0]        address;
      logic [7:0]        float_data;
      logic [31:0]       cycle_now;
      logic [CHAN_W-1:0] channel;
      logic [7:0]        position;
      logic              pressed;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       strobe_res;
      logic [3:0] annunciators;
      logic       annunciator_changed;
   } rsp_type;

   // state updates produced by one request
   typedef struct packed {
      logic [3:0]         ann;
      logic               tmr_we;
      logic [31:0]        tmr_value;
      logic               pad_we;
      logic               btn_we;
      logic [CHAN_W-1:0]  chan;
      logic [LIMIT_W-1:0] limit;
      logic               pressed;
   } upd_type;

   // current state; channels not built read as zero
   typedef struct packed {
      logic [3:0]                            ann;
      logic [MAX_CHANNELS-1:0]               buttons;
      logic [MAX_CHANNELS-1:0][LIMIT_W-1:0]  limits;
      logic [31:0]                           timer_start;
   } state_type;

   // position*11 + 8, done as shifts and adds
   function automatic logic [LIMIT_W-1:0] paddle_limit(input logic [7:0] pos);
      logic [LIMIT_W-1:0] p;
      p = LIMIT_W'(pos);
      return (p << 3) + (p << 1) + p + LIMIT_W'(8);
   endfunction

endpackage

`default_nettype wire

/* src/gpps_decode.sv */
// Address and action decode: builds the response and the state update.
`default_nettype none

module gpps_decode (
   input  gpps_pkg::item_type  item,
   input  gpps_pkg::state_type st,
   output gpps_pkg::rsp_type   rsp,
   output gpps_pkg::upd_type   upd
);
   import gpps_pkg::*;

   logic [31:0]        elapsed;
   logic [LIMIT_W-1:0] lim;
   logic               pending;
   logic               is_read;
   logic               top_bit;
   logic [3:0]         ann_next;

   assign elapsed = item.cycle_now - st.timer_start;
   assign lim     = st.limits[item.address[1:0]];
   // unbuilt channels have limit zero, so never pending
   assign pending = (elapsed[31:LIMIT_W] == '0) && (elapsed[LIMIT_W-1:0] < lim);
   assign is_read = (item.action == ACT_READ);
   assign top_bit = item.address[2] ? pending : st.buttons[item.address[1:0]];

   always_comb begin
      rsp      = '0;
      ann_next = st.ann;
      upd           = '0;
      upd.tmr_value = item.cycle_now;
      upd.chan      = item.channel;
      upd.limit     = paddle_limit(item.position);
      upd.pressed   = item.pressed;
      unique case (item.action) inside
         ACT_READ, ACT_WRITE: begin
            if (is_read) rsp.read_data = item.float_data;
            if (item.address[5:4] == 2'b00) begin
               rsp.strobe_res = 1'b1;
            end else if (item.address[5:3] == 3'b011) begin
               ann_next[item.address[2:1]] = item.address[0];
            end else if (item.address[5:4] == 2'b11) begin
               upd.tmr_we = 1'b1;
            end else if (item.address[5] && is_read) begin
               rsp.read_data = {top_bit, item.float_data[6:0]};
            end
         end
         ACT_SET_PADDLE: upd.pad_we = 1'b1;
         ACT_SET_BUTTON: upd.btn_we = 1'b1;
         ACT_POWER_OFF:  ann_next = '0;
         default: ;
      endcase
      upd.ann                 = ann_next;
      rsp.annunciators        = ann_next;
      rsp.annunciator_changed = (ann_next != st.ann);
   end

endmodule

`default_nettype wire

/* src/gpps_state.sv */
// Annunciator, button, paddle limit and timer start registers.
`default_nettype none

module gpps_state #(
   parameter int NUM_CHANNELS = gpps_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                commit,
   input  gpps_pkg::upd_type   upd,
   output gpps_pkg::state_type st
);
   import gpps_pkg::*;

   logic [3:0]  ann_ff;
   logic [31:0] timer_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ann_ff         <= '0;
         timer_start_ff <= '0;
      end else if (commit) begin
         ann_ff <= upd.ann;
         if (upd.tmr_we) timer_start_ff <= upd.tmr_value;
      end
   end

   assign st.ann         = ann_ff;
   assign st.timer_start = timer_start_ff;

   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_chan
      if (i < NUM_CHANNELS) begin : g_on
         logic               button_ff;
         logic [LIMIT_W-1:0] limit_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               button_ff <= 1'b0;
               limit_ff  <= MID_LIMIT;
            end else if (commit && upd.chan == CHAN_W'(i)) begin
               if (upd.btn_we) button_ff <= upd.pressed;
               if (upd.pad_we) limit_ff  <= upd.limit;
            end
         end

         assign st.buttons[i] = button_ff;
         assign st.limits[i]  = limit_ff;
      end else begin : g_off
         assign st.buttons[i] = 1'b0;
         assign st.limits[i]  = '0;
      end
   end

endmodule

`default_nettype wire

/* src/game_port_paddle_switches.sv */
// Game port soft switches, buttons and paddle timers: top level.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   req     | req_valid/ready    | action, address, float_data, cycle_now,
//           |                    | channel, position, pressed
//   rsp     | rsp_valid/ready    | read_data, strobe_res, annunciators,
//           |                    | annunciator_changed
//
// One request per cycle while responses are taken; a request passes through the
// input register, decode and the response register before its response is valid.
// State is updated when a request moves from the input to the response register.
// A stalled response holds the pipe; the input register still takes a request
// while it is empty or moving on to the response register.
// Synchronous active-high reset: annunciators off, buttons up, limits 1410.
`default_nettype none

module game_port_paddle_switches #(
   parameter int NUM_CHANNELS = gpps_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_action,
   input  logic [5:0]                  req_address,
   input  logic [7:0]                  req_float_data,
   input  logic [31:0]                 req_cycle_now,
   input  logic [gpps_pkg::CHAN_W-1:0] req_channel,
   input  logic [7:0]                  req_position,
   input  logic                        req_pressed,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_read_data,
   output logic                        rsp_strobe_res,
   output logic [3:0]                  rsp_annunciators,
   output logic                        rsp_annunciator_changed
);
   import gpps_pkg::*;

   logic      in_valid_ff, in_valid_in;
   item_type  item_ff;
   logic      out_valid_ff, out_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_comb;
   upd_type   upd;
   state_type st;
   logic      advance;
   logic      commit;
   logic      req_take;

   assign advance  = !out_valid_ff || rsp_ready;
   assign commit   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_take = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.action     <= req_action;
         item_ff.address    <= req_address;
         item_ff.float_data <= req_float_data;
         item_ff.cycle_now  <= req_cycle_now;
         item_ff.channel    <= req_channel;
         item_ff.position   <= req_position;
         item_ff.pressed    <= req_pressed;
      end
      if (commit) rsp_ff <= rsp_comb;
   end

   gpps_decode u_decode (
      .item (item_ff),
      .st   (st),
      .rsp  (rsp_comb),
      .upd  (upd)
   );

   gpps_state #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .upd    (upd),
      .st     (st)
   );

   assign rsp_valid               = out_valid_ff;
   assign rsp_read_data           = rsp_ff.read_data;
   assign rsp_strobe_res          = rsp_ff.strobe_res;
   assign rsp_annunciators        = rsp_ff.annunciators;
   assign rsp_annunciator_changed = rsp_ff.annunciator_changed;

`include "assert_macros.svh"

   `GPPS_ASSERT(a_ann_matches_state, clock, reset, commit |=> rsp_annunciators == st.ann)
   `GPPS_ASSERT(a_power_off_clears, clock, reset, (commit && item_ff.action == ACT_POWER_OFF) |=> st.ann == '0)
   `GPPS_ASSERT_NEVER(a_no_overwrite, clock, reset, req_take && in_valid_ff && !advance)

endmodule

`default_nettype wire
